// ----- rtl/core/tra_pkg.sv -----
package tra_pkg;

  localparam int SPEED_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 32;

  localparam int MUL_CHUNK = 16;

  localparam int PERSIST_BITS = 8;
  localparam logic [PERSIST_BITS-1:0] PERSIST_RESET = 8'd50;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic cap;        // take the input beat
    logic clr;        // zero count and averages
    logic mul_clr;    // zero product, load weight
    logic mul_step;   // one weight chunk through the multiplier
    logic div_init;   // add sample, load divider
    logic div_step;   // one quotient bit
    logic div_store;  // write quotient to the selected average
    logic sel;        // 0 = cumulative mean, 1 = recent average
    logic commit;     // load output register, bump count
  } tra_cmd_t;

endpackage

// ----- rtl/core/tra_ctrl.sv -----
module tra_ctrl #(
  parameter int ACC_BITS  = 40,
  parameter int MUL_STEPS = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  output tra_pkg::tra_cmd_t cmd
);

  localparam int CNT_W = $clog2(ACC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_STORE,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               sel_r;
  logic               out_valid_r;
  logic               accept;
  logic               out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.sel       = sel_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.cap = accept;
        cmd.clr = accept && (in_operation == tra_pkg::OP_CLEAR);
      end
      S_LOAD:  cmd.mul_clr   = 1'b1;
      S_MUL:   cmd.mul_step  = 1'b1;
      S_DINIT: cmd.div_init  = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_STORE: cmd.div_store = 1'b1;
      S_DONE:  cmd.commit    = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sel_r <= 1'b0;
            if (in_operation == tra_pkg::OP_CLEAR) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          cnt_r   <= CNT_W'(MUL_STEPS - 1);
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (cnt_r == '0) begin
            state_r <= S_DINIT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DINIT: begin
          cnt_r   <= CNT_W'(ACC_BITS - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_STORE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_STORE: begin
          // second pass runs the recent average
          if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/tra_dp.sv -----
module tra_dp #(
  parameter int SPEED_BITS = 32,
  parameter int FRAC_BITS  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tra_pkg::tra_cmd_t                    cmd,
  input  logic [SPEED_BITS-1:0]                in_sample_speed,
  input  logic                                 cfg_we,
  input  logic [tra_pkg::PERSIST_BITS-1:0]     cfg_data,
  output logic [SPEED_BITS-1:0]                out_inst_speed,
  output logic [SPEED_BITS+FRAC_BITS-1:0]      out_mean_speed,
  output logic [SPEED_BITS+FRAC_BITS-1:0]      out_recent_speed
);

  localparam int ACC_BITS  = SPEED_BITS + FRAC_BITS;
  localparam int CHUNK     = tra_pkg::MUL_CHUNK;
  localparam int MUL_STEPS = (COUNT_BITS + CHUNK - 1) / CHUNK;
  localparam int WPAD      = MUL_STEPS * CHUNK;
  localparam int PROD_W    = ACC_BITS + WPAD;
  localparam int SUM_W     = PROD_W + 1;
  localparam int PART_W    = ACC_BITS + CHUNK;

  logic [SPEED_BITS-1:0]             x_r;
  logic                              clr_r;
  logic [tra_pkg::PERSIST_BITS-1:0]  persist_r;
  logic [ACC_BITS-1:0]               mean_r;
  logic [ACC_BITS-1:0]               recent_r;
  logic [COUNT_BITS-1:0]             count_r;
  logic [WPAD-1:0]                   wsh_r;
  logic [PROD_W-1:0]                 prod_r;
  logic [COUNT_BITS:0]               d_r;
  logic [COUNT_BITS:0]               rem_r;
  logic [ACC_BITS-1:0]               num_r;
  logic [ACC_BITS-1:0]               quo_r;
  logic [SPEED_BITS-1:0]             out_inst_r;
  logic [ACC_BITS-1:0]               out_mean_r;
  logic [ACC_BITS-1:0]               out_recent_r;

  logic [COUNT_BITS-1:0]             persist_ext;
  logic [COUNT_BITS-1:0]             w_lim;
  logic [COUNT_BITS-1:0]             w_sel;
  logic [ACC_BITS-1:0]               a_sel;
  logic [CHUNK-1:0]                  chunk;
  logic [PART_W-1:0]                 part;
  logic [PROD_W-1:0]                 prod_nxt;
  logic [ACC_BITS-1:0]               xs;
  logic [SUM_W-1:0]                  sum;
  logic [COUNT_BITS+1:0]             trial;
  logic [COUNT_BITS+1:0]             diff;
  logic                              ge;
  logic                              count_sat;

  assign persist_ext = COUNT_BITS'(persist_r);
  assign w_lim       = (count_r < persist_ext) ? count_r : persist_ext;
  assign w_sel       = cmd.sel ? w_lim : count_r;
  assign a_sel       = cmd.sel ? recent_r : mean_r;
  assign chunk       = wsh_r[WPAD-1 -: CHUNK];
  assign part        = PART_W'(a_sel) * PART_W'(chunk);
  assign prod_nxt    = (prod_r << CHUNK) + PROD_W'(part);
  assign xs          = ACC_BITS'(x_r) << FRAC_BITS;
  assign sum         = SUM_W'(prod_r) + SUM_W'(xs);
  assign trial       = {rem_r, num_r[ACC_BITS-1]};
  assign diff        = trial - {1'b0, d_r};
  assign ge          = (trial >= {1'b0, d_r});
  assign count_sat   = &count_r;

  // averages, count and limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r    <= '0;
      recent_r  <= '0;
      count_r   <= '0;
      persist_r <= tra_pkg::PERSIST_RESET;
    end else begin
      if (cfg_we) begin
        persist_r <= cfg_data;
      end
      if (cmd.clr) begin
        mean_r   <= '0;
        recent_r <= '0;
        count_r  <= '0;
      end
      if (cmd.div_store) begin
        if (cmd.sel) begin
          recent_r <= quo_r;
        end else begin
          mean_r <= quo_r;
        end
      end
      if (cmd.commit && !clr_r && !count_sat) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // input capture, multiplier, divider and output register
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      x_r   <= cmd.clr ? '0 : in_sample_speed;
      clr_r <= cmd.clr;
    end
    if (cmd.mul_clr) begin
      prod_r <= '0;
      wsh_r  <= WPAD'(w_sel);
    end
    if (cmd.mul_step) begin
      prod_r <= prod_nxt;
      wsh_r  <= wsh_r << CHUNK;
    end
    if (cmd.div_init) begin
      d_r   <= (COUNT_BITS + 1)'(w_sel) + 1'b1;
      // top part is already below the divisor since the quotient fits
      rem_r <= sum[ACC_BITS+COUNT_BITS:ACC_BITS];
      num_r <= sum[ACC_BITS-1:0];
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? diff[COUNT_BITS:0] : trial[COUNT_BITS:0];
      num_r <= num_r << 1;
      quo_r <= {quo_r[ACC_BITS-2:0], ge};
    end
    if (cmd.commit) begin
      out_inst_r   <= x_r;
      out_mean_r   <= mean_r;
      out_recent_r <= recent_r;
    end
  end

  assign out_inst_speed   = out_inst_r;
  assign out_mean_speed   = out_mean_r;
  assign out_recent_speed = out_recent_r;

endmodule

// ----- rtl/core/throughput_running_averager_top.sv -----
// Sample beat: two passes (cumulative mean, then recent average), each of load, multiply, divide
// and store; no new beat is accepted until the result is committed (in_stall while not idle).
// Cost is set by the shared restoring divider, one quotient bit per cycle, run twice.
// Clear beat: skips both passes and goes straight to commit; out_valid is registered on commit.
// Reset (rst_n low, synchronous): count and both averages zero, persist_limit 50.
module throughput_running_averager_top #(
  parameter int SPEED_BITS = tra_pkg::SPEED_BITS_DEF,
  parameter int FRAC_BITS  = tra_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = tra_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [SPEED_BITS-1:0]              in_sample_speed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [SPEED_BITS-1:0]              out_inst_speed,
  output logic [SPEED_BITS+FRAC_BITS-1:0]    out_mean_speed,
  output logic [SPEED_BITS+FRAC_BITS-1:0]    out_recent_speed,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tra_pkg::PERSIST_BITS-1:0]   cfg_data
);

  localparam int ACC_BITS  = SPEED_BITS + FRAC_BITS;
  localparam int MUL_STEPS = (COUNT_BITS + tra_pkg::MUL_CHUNK - 1) / tra_pkg::MUL_CHUNK;

  tra_pkg::tra_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tra_ctrl #(
    .ACC_BITS  (ACC_BITS),
    .MUL_STEPS (MUL_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  tra_dp #(
    .SPEED_BITS (SPEED_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_sample_speed  (in_sample_speed),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_inst_speed   (out_inst_speed),
    .out_mean_speed   (out_mean_speed),
    .out_recent_speed (out_recent_speed)
  );

  // never overwrite a result still waiting downstream
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without valid result");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.mul_clr, cmd.mul_step, cmd.div_init, cmd.div_step,
              cmd.div_store, cmd.commit}))
    else $error("overlapping datapath commands");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && in_stall && $past(cmd.clr)) |=>
      (out_inst_speed == '0) && (out_mean_speed == '0) && (out_recent_speed == '0))
    else $error("clear result not zero");

endmodule
